[rtl/bms_pkg.sv]
// Package for the buzzer melody sequencer: action codes, register indexes, play
// and sequencer states, divider structs, note frequency table. No dependencies.
package bms_pkg;

	typedef enum logic [2:0] {
		ACT_LOAD    = 3'd0,
		ACT_PLAY    = 3'd1,
		ACT_PAUSE   = 3'd2,
		ACT_RESTART = 3'd3,
		ACT_STOP    = 3'd4,
		ACT_TICK    = 3'd5,
		ACT_PEND    = 3'd6,
		ACT_NONE    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_PLAYING = 2'd1,
		MODE_PAUSED  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_VOLUME = 3'd0,
		REG_TEMPO  = 3'd1,
		REG_BASE   = 3'd2,
		REG_SHIFT  = 3'd3,
		REG_LOOP   = 3'd4,
		REG_SECS   = 3'd5,
		REG_LENGTH = 3'd6
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_DUR,
		ST_SCALE,
		ST_TONE,
		ST_PER,
		ST_CMP,
		ST_CYC,
		ST_OUT
	} seq_t;

	// Divider request and reply between sequencer and shared divider.
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	// Note frequencies in 0.1 Hz; entry 0 is a rest.
	function automatic logic [12:0] freq_tenth(input logic [2:0] idx);
		case (idx)
			3'd1: freq_tenth = 13'd2616;
			3'd2: freq_tenth = 13'd2936;
			3'd3: freq_tenth = 13'd3296;
			3'd4: freq_tenth = 13'd3492;
			3'd5: freq_tenth = 13'd3920;
			3'd6: freq_tenth = 13'd4400;
			3'd7: freq_tenth = 13'd4939;
			default: freq_tenth = 13'd0;
		endcase
	endfunction

endpackage

[rtl/bms_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on bms_pkg for the request and reply structs.
module bms_div (
	input  logic            clk,
	input  logic            arst_n,
	input  bms_pkg::div_req_t req,
	output bms_pkg::div_rsp_t rsp
);
	import bms_pkg::*;

	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial;

	// Shift in the next numerator bit and try a subtraction.
	always_comb begin
		trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

[rtl/bms_song_mem.sv]
// Synchronous note store with one write and one read port, registered read.
// No dependencies.
module bms_song_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/buzzer_melody_sequencer_top.sv]
// Top level of the buzzer melody sequencer: control sequencer, note store
// and shared divider. Depends on bms_pkg, bms_song_mem, bms_div.
//
// Usage: the in channel (in_valid/in_ready) takes one action beat with
// action, note_slot and note_word. Each beat yields exactly one result beat
// on the out channel (out_valid/out_ready) with tone_on, tone_period,
// tone_compare, play_state and song_position. The cfg channel writes one
// register per beat (cfg_index, cfg_data); the user must write only while
// the block is idle, which the block itself does not enforce. Most actions
// give their result in the cycle after acceptance. A millisecond tick that
// starts a note reads the note store, splits the word by reciprocal
// multiplication and runs the shared divider three times (tempo scale,
// period, compare); a rest skips the last two divides.
// One item is handled at a time; the next is taken once the result beat
// has left the output register.
// Reset clears play state, counters and registers to their defaults; the
// note store is not cleared and must be loaded before use. A stalled
// receiver holds the result and the block takes no new input.
module buzzer_melody_sequencer_top #(
	parameter int SONG_DEPTH     = 256,
	parameter int TIMER_CLOCK_HZ = 1000000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  note_slot,
	input  logic [31:0] note_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tone_on,
	output logic [15:0] tone_period,
	output logic [15:0] tone_compare,
	output logic [1:0]  play_state,
	output logic [8:0]  song_position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bms_pkg::*;

	localparam int AW = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
	localparam logic [63:0] NUM20 = 64'(TIMER_CLOCK_HZ) * 64'd20;
	localparam logic [16:0] DEPTH_C = 17'(SONG_DEPTH);
	// Reciprocals for the constant divides by 100, 10 and 625.
	localparam logic [63:0] RECIP100 = 64'h51EB851F;
	localparam logic [63:0] RECIP10  = 64'hCCCCCCCD;
	localparam logic [63:0] RECIP625 = 64'hD1B71759;

	// Configuration registers.
	logic [6:0]  volume_q;
	logic [15:0] tempo_q, base_q, secs_q;
	logic [3:0]  shift_q;
	logic        loop_q;
	logic [8:0]  len_q;

	// Play state.
	mode_t       mode_q;
	logic [8:0]  pos_q;
	logic [31:0] now_q, next_q, stop_q, cyc_q;
	logic [2:0]  tune_q;
	logic        run_q;
	logic [15:0] per_q, cmp_q;

	// Note computation scratch.
	seq_t        st_q, st_d;
	logic [6:0]  word_q;
	logic [25:0] q100_q;
	logic [15:0] dur_q;
	logic [15:0] tone_ms_q;
	logic [29:0] cprod_q;
	logic [19:0] dur9;
	logic [20:0] d_q;
	logic [6:0]  code_q;

	// Output register.
	logic        ov_q;

	logic        in_acc, out_acc;
	logic [16:0] eff_len;
	logic        we;
	logic [31:0] rdata;
	logic [8:0]  pos_sel;
	logic [AW-1:0] raddr;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign eff_len   = ({8'd0, len_q} < DEPTH_C) ? {8'd0, len_q} : DEPTH_C;
	assign in_ready  = (st_q == ST_IDLE) && !ov_q;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign cfg_ready = 1'b1;
	assign we        = in_acc && (action == ACT_LOAD) && ({9'd0, note_slot} < DEPTH_C);
	// The store is addressed with the position the tick will play from.
	assign raddr     = AW'(pos_sel);

	bms_song_mem #(.DEPTH(SONG_DEPTH), .AW(AW)) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(note_slot)),
		.wdata(note_word),
		.raddr(raddr),
		.rdata(rdata)
	);

	bms_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Pitch-shifted note index and doubled octave multiplier.
	logic signed [4:0] sh;
	logic signed [5:0] tt;
	logic [7:0]  key2_base, key2;
	logic [2:0]  tidx;
	always_comb begin
		sh        = ($signed(shift_q) < -4'sd7) ? -5'sd7 : 5'($signed(shift_q));
		key2_base = {2'b00, code_q[6:3], 2'b00};
		if (key2_base < 8'd2) key2_base = 8'd2;
		tt   = 6'($signed({3'b000, code_q[2:0]})) + 6'(sh);
		key2 = key2_base;
		tidx = tt[2:0];
		if (tt >= 6'sd8) begin
			tidx = 3'(tt - 6'sd7);
			key2 = {key2_base[6:0], 1'b0};
		end else if (tt <= 6'sd0) begin
			tidx = 3'(tt + 6'sd7);
			key2 = {1'b0, key2_base[7:1]};
		end
	end

	// Nine times the note duration, for the tone length.
	assign dur9 = {1'b0, dur_q, 3'b000} + {4'd0, dur_q};

	// Next-state logic of the sequencer.
	logic start_note;
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (start_note) st_d = ST_RD;
			ST_RD:    st_d = ST_DUR;
			ST_DUR:   st_d = ST_SCALE;
			ST_SCALE: if (drsp.done) st_d = ST_TONE;
			ST_TONE:  st_d = (code_q[2:0] == 3'd0) ? ST_OUT : ST_PER;
			ST_PER:   if (drsp.done) st_d = ST_CMP;
			ST_CMP:   if (drsp.done) st_d = ST_CYC;
			ST_CYC:   st_d = ST_OUT;
			ST_OUT:   st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// Divider requests issued on entry to each divide state.
	logic [15:0] tempo_eff;
	logic [6:0]  vol_sat;
	assign tempo_eff = (tempo_q == 16'd0) ? 16'd1 : tempo_q;
	assign vol_sat   = (volume_q > 7'd100) ? 7'd100 : volume_q;
	always_comb begin
		dreq = '0;
		case (st_q)
			ST_DUR: begin
				dreq.start = 1'b1;
				dreq.num   = 64'(q100_q[15:0]) * 64'(base_q);
				dreq.den   = 64'(tempo_eff);
			end
			ST_TONE: if (code_q[2:0] != 3'd0) begin
				dreq.start = 1'b1;
				dreq.num   = NUM20;
				dreq.den   = 64'(d_q);
			end
			ST_PER: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num   = (NUM20 >= 64'(d_q)) ? (NUM20 - 64'(d_q)) * 64'(vol_sat) : 64'd0;
				dreq.den   = 64'(d_q) * 64'd100;
			end
			default: dreq = '0;
		endcase
	end

	// Tick preconditions evaluated from current state.
	logic [31:0] now_n, stop_n;
	logic [8:0]  pos_t;
	logic        tick_live, tick_stop, tick_wrap_stop;
	always_comb begin
		now_n     = now_q + 32'd1;
		stop_n    = (stop_q == 32'd0) ? now_n + 32'(secs_q) * 32'd1000 : stop_q;
		pos_t     = (stop_q == 32'd0) ? 9'd0 : pos_q;
		pos_sel   = ({8'd0, pos_t} >= eff_len) ? 9'd0 : pos_t;
		tick_live = (mode_q == MODE_PLAYING) && (eff_len != 17'd0) && (secs_q != 16'd0);
		tick_stop = now_n >= stop_n;
		tick_wrap_stop = ({8'd0, pos_t} >= eff_len) && !loop_q;
		start_note = in_acc && (action == ACT_TICK) && tick_live && !tick_stop
			&& (now_n >= next_q) && !tick_wrap_stop;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= 7'd10;
			tempo_q  <= 16'd120;
			base_q   <= 16'd120;
			shift_q  <= 4'd0;
			loop_q   <= 1'b0;
			secs_q   <= 16'd10;
			len_q    <= 9'd0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_VOLUME: volume_q <= cfg_data[6:0];
				REG_TEMPO:  tempo_q  <= cfg_data;
				REG_BASE:   base_q   <= cfg_data;
				REG_SHIFT:  shift_q  <= cfg_data[3:0];
				REG_LOOP:   loop_q   <= cfg_data[0];
				REG_SECS:   secs_q   <= cfg_data;
				REG_LENGTH: len_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Play state update and note computation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			mode_q <= MODE_STOPPED;
			pos_q  <= '0;
			now_q  <= '0;
			next_q <= '0;
			stop_q <= '0;
			cyc_q  <= '0;
			tune_q <= '0;
			run_q  <= 1'b0;
			per_q  <= '0;
			cmp_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_acc) ov_q <= 1'b0;
			if (st_q == ST_OUT) ov_q <= 1'b1;
			if (in_acc) begin
				if (!start_note) ov_q <= 1'b1;
				case (action_t'(action))
					ACT_PLAY: begin
						if (mode_q == MODE_PAUSED) mode_q <= MODE_PLAYING;
						else if (mode_q == MODE_STOPPED && secs_q != 16'd0
							&& eff_len != 17'd0) begin
							pos_q <= '0; next_q <= '0; stop_q <= '0;
							mode_q <= MODE_PLAYING;
						end
					end
					ACT_PAUSE: if (mode_q == MODE_PLAYING) begin
						run_q <= 1'b0; mode_q <= MODE_PAUSED;
					end
					ACT_RESTART: if (eff_len != 17'd0) begin
						run_q <= 1'b0;
						pos_q <= '0; next_q <= '0; stop_q <= '0;
						mode_q <= MODE_PLAYING;
					end
					ACT_STOP: begin
						run_q <= 1'b0; tune_q <= '0; cyc_q <= '0; pos_q <= '0;
						next_q <= '0; stop_q <= '0; mode_q <= MODE_STOPPED;
					end
					ACT_TICK: begin
						now_q <= now_n;
						if (tick_live) begin
							if (tick_stop || ((now_n >= next_q) && tick_wrap_stop)) begin
								run_q <= 1'b0; tune_q <= '0; cyc_q <= '0; pos_q <= '0;
								next_q <= '0; stop_q <= '0; mode_q <= MODE_STOPPED;
							end else begin
								stop_q <= stop_n;
								pos_q  <= start_note ? pos_sel : pos_t;
							end
						end
					end
					ACT_PEND: if (run_q) begin
						if (cyc_q != 32'd0 && tune_q != 3'd0) cyc_q <= cyc_q - 32'd1;
						else run_q <= 1'b0;
					end
					default: ;
				endcase
			end
			case (st_q)
				ST_RD: pos_q <= pos_q + 9'd1;
				ST_SCALE: if (drsp.done) begin
					next_q <= now_q + 32'(drsp.quo[15:0]);
					tune_q <= code_q[2:0];
					run_q  <= 1'b0;
				end
				ST_PER: if (drsp.done)
					per_q <= (drsp.quo == 64'd0) ? 16'd0 :
						((drsp.quo - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(drsp.quo - 64'd1);
				ST_CMP: if (drsp.done)
					cmp_q <= (drsp.quo > 64'd65535) ? 16'hFFFF : drsp.quo[15:0];
				ST_CYC: begin
					// Tone cycles: product over 32, then over 625.
					cyc_q <= 32'((64'(cprod_q) * RECIP625) >> 41);
					run_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Scratch registers for the note being computed.
	always_ff @(posedge clk) begin
		if (st_q == ST_RD) begin
			word_q <= rdata[6:0];
			q100_q <= 26'((64'(rdata) * RECIP100) >> 37);
		end
		// Tune code is the word minus a hundred times the quotient, kept to 7 bits.
		if (st_q == ST_DUR) code_q <= word_q - 7'(q100_q[6:0] * 7'd100);
		if (st_q == ST_SCALE && drsp.done) begin
			dur_q <= drsp.quo[15:0];
			d_q   <= 21'(freq_tenth(tidx)) * 21'(key2);
		end
		if (st_q == ST_TONE) tone_ms_q <= 16'((64'(dur9) * RECIP10) >> 35);
		if (st_q == ST_PER) cprod_q <= 30'((64'(d_q) * 64'(tone_ms_q)) >> 5);
	end

	assign out_valid     = ov_q;
	assign tone_on       = run_q;
	assign tone_period   = per_q;
	assign tone_compare  = cmp_q;
	assign play_state    = mode_q;
	assign song_position = pos_q;
endmodule

[verif/buzzer_melody_sequencer_top_tb.sv]
// Self-checking testbench for buzzer_melody_sequencer_top: a scoreboard class
// predicts every result beat from the accepted action beats. Depends on bms_pkg.
module buzzer_melody_sequencer_top_tb;
	import bms_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic        on;
		logic [15:0] period;
		logic [15:0] compare;
		logic [1:0]  state;
		logic [8:0]  pos;
	} tone_result_t;

	// Tracks the sequencer state and holds the results it expects to see.
	class melody_scoreboard;
		logic [31:0]  song[256];
		mode_t        mode;
		logic [8:0]   pos;
		logic [31:0]  now_ms, next_ms, stop_ms, cycles_left;
		logic [2:0]   tune;
		logic         pwm_on;
		logic [15:0]  period, compare;
		logic [6:0]   vol;
		logic [15:0]  tempo, base, secs;
		logic signed [3:0] shift;
		logic         loop_on;
		logic [8:0]   song_len;
		tone_result_t pending[$];
		int           errors;

		function new();
			mode = MODE_STOPPED;
			pos = 0; now_ms = 0; next_ms = 0; stop_ms = 0; cycles_left = 0;
			tune = 0; pwm_on = 0; period = 0; compare = 0;
			vol = 10; tempo = 120; base = 120; secs = 10;
			shift = 0; loop_on = 0; song_len = 0; errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] data);
			case (idx)
				REG_VOLUME: vol = data[6:0];
				REG_TEMPO:  tempo = data;
				REG_BASE:   base = data;
				REG_SHIFT:  shift = data[3:0];
				REG_LOOP:   loop_on = data[0];
				REG_SECS:   secs = data;
				REG_LENGTH: song_len = data[8:0];
				default: ;
			endcase
		endfunction

		function logic [8:0] active_len();
			return (song_len < 9'd256) ? song_len : 9'd256;
		endfunction

		function void halt();
			pwm_on = 0; tune = 0; cycles_left = 0; pos = 0;
			next_ms = 0; stop_ms = 0; mode = MODE_STOPPED;
		endfunction

		// Sets up the PWM for one note code and the tone length in ms.
		function void start_tone(int unsigned code, logic [31:0] tone_ms);
			int unsigned freq[8] = '{0, 2616, 2936, 3296, 3492, 3920, 4400, 4939};
			int unsigned key2, t;
			int sh, tt;
			logic [63:0] d, num, p, c, v, cyc;
			key2 = (code / 8) * 4;
			t = code % 8;
			if (key2 < 2)
				key2 = 2;
			tune = 3'(t);
			pwm_on = 0;
			if (t > 0) begin
				sh = (shift < -7) ? -7 : int'(shift);
				tt = t + sh;
				if (tt >= 8) begin
					tt -= 7;
					key2 *= 2;
				end else if (tt <= 0) begin
					tt += 7;
					key2 /= 2;
				end
				d = 64'(freq[tt & 7]) * key2;
				num = 64'd20000000;
				p = num / d;
				p = (p > 0) ? p - 1 : 0;
				v = (vol > 100) ? 100 : vol;
				c = (num >= d) ? ((num - d) * v) / (100 * d) : 0;
				period = (p > 65535) ? 16'hFFFF : p[15:0];
				compare = (c > 65535) ? 16'hFFFF : c[15:0];
				cyc = (d * tone_ms) / 20000;
				cycles_left = cyc[31:0];
				pwm_on = 1;
			end
		endfunction

		// One millisecond of playback.
		function void tick();
			logic [31:0] word, dur, tmp;
			if (mode != MODE_PLAYING || active_len() == 0 || secs == 0)
				return;
			if (stop_ms == 0) begin
				stop_ms = now_ms + secs * 32'd1000;
				pos = 0;
			end
			if (now_ms >= stop_ms) begin
				halt();
				return;
			end
			if (now_ms < next_ms)
				return;
			if (pos >= active_len()) begin
				if (loop_on) begin
					pos = 0;
				end else begin
					halt();
					return;
				end
			end
			word = song[pos[7:0]];
			pos++;
			tmp = (tempo == 0) ? 32'd1 : 32'(tempo);
			dur = (word / 100) & 32'hFFFF;
			dur = ((dur * base) / tmp) & 32'hFFFF;
			start_tone(word % 100, dur * 9 / 10);
			next_ms = now_ms + dur;
		endfunction

		// Notes an accepted action beat and queues its expected result.
		function void note_action(action_t act, logic [7:0] slot, logic [31:0] word);
			case (act)
				ACT_LOAD: song[slot] = word;
				ACT_PLAY: begin
					if (mode == MODE_PAUSED) begin
						mode = MODE_PLAYING;
					end else if (mode == MODE_STOPPED && secs > 0 && active_len() > 0) begin
						pos = 0; next_ms = 0; stop_ms = 0; mode = MODE_PLAYING;
					end
				end
				ACT_PAUSE: begin
					if (mode == MODE_PLAYING) begin
						pwm_on = 0;
						mode = MODE_PAUSED;
					end
				end
				ACT_RESTART: begin
					if (active_len() > 0) begin
						pwm_on = 0; pos = 0; next_ms = 0; stop_ms = 0;
						mode = MODE_PLAYING;
					end
				end
				ACT_STOP: halt();
				ACT_TICK: begin
					now_ms++;
					tick();
				end
				ACT_PEND: begin
					if (pwm_on) begin
						if (cycles_left > 0 && tune > 0)
							cycles_left--;
						else
							pwm_on = 0;
					end
				end
				default: ;
			endcase
			pending.push_back('{pwm_on, period, compare, mode, pos});
		endfunction

		// Compares one result beat with the oldest expectation.
		function void check_result(tone_result_t got);
			tone_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.on !== exp_r.on) begin
				$display("%0t: tone_on exp %0d got %0d", $time, exp_r.on, got.on);
				errors++;
			end
			if (got.period !== exp_r.period) begin
				$display("%0t: tone_period exp %0d got %0d", $time, exp_r.period, got.period);
				errors++;
			end
			if (got.compare !== exp_r.compare) begin
				$display("%0t: tone_compare exp %0d got %0d", $time, exp_r.compare,
					got.compare);
				errors++;
			end
			if (got.state !== exp_r.state) begin
				$display("%0t: play_state exp %0d got %0d", $time, exp_r.state, got.state);
				errors++;
			end
			if (got.pos !== exp_r.pos) begin
				$display("%0t: song_position exp %0d got %0d", $time, exp_r.pos, got.pos);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  action = ACT_NONE;
	logic [7:0]  note_slot = 0;
	logic [31:0] note_word = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        tone_on;
	logic [15:0] tone_period, tone_compare;
	logic [1:0]  play_state;
	logic [8:0]  song_position;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;

	melody_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;
	int cycles = 0;

	buzzer_melody_sequencer_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .note_slot(note_slot), .note_word(note_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.tone_on(tone_on), .tone_period(tone_period), .tone_compare(tone_compare),
		.play_state(play_state), .song_position(song_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver readiness, with an optional long hold-off.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result beats go to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{tone_on, tone_period, tone_compare, play_state, song_position});
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offers one action beat and returns at the edge that accepts it.
	task automatic send_action(action_t act, logic [7:0] slot, logic [31:0] word);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= act;
		note_slot <= slot;
		note_word <= word;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_action(act, slot, word);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drops valid and waits until every result beat has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_all(int v, int t, int b, int s, int l, int secs, int len);
		write_reg(REG_VOLUME, 16'(v));
		write_reg(REG_TEMPO, 16'(t));
		write_reg(REG_BASE, 16'(b));
		write_reg(REG_SHIFT, 16'(s));
		write_reg(REG_LOOP, 16'(l));
		write_reg(REG_SECS, 16'(secs));
		write_reg(REG_LENGTH, 16'(len));
	endtask

	// Mostly short notes so the song actually advances.
	function automatic logic [31:0] rand_note();
		if ($urandom_range(9) < 8)
			return $urandom_range(30) * 100 + $urandom_range(99);
		return $urandom;
	endfunction

	task automatic random_beat();
		int r;
		logic [7:0]  s;
		logic [31:0] w;
		r = $urandom_range(99);
		s = 8'($urandom);
		w = $urandom;
		if (r < 45)
			send_action(ACT_TICK, s, w);
		else if (r < 68)
			send_action(ACT_PEND, s, w);
		else if (r < 76)
			send_action(ACT_LOAD, s, rand_note());
		else if (r < 82)
			send_action(ACT_PLAY, s, w);
		else if (r < 86)
			send_action(ACT_PAUSE, s, w);
		else if (r < 90)
			send_action(ACT_RESTART, s, w);
		else if (r < 93)
			send_action(ACT_STOP, s, w);
		else
			send_action(ACT_NONE, s, w);
	endtask

	initial begin
		int phase_cfg[7][7] = '{
			'{100, 120, 120, 7, 1, 65535, 256},
			'{127, 0, 65535, -8, 0, 1, 300},
			'{0, 65535, 1, -7, 1, 0, 511},
			'{55, 200, 100, 3, 1, 2, 16},
			'{10, 120, 120, 0, 0, 10, 0},
			'{10, 60, 240, -3, 0, 5, 40},
			'{100, 90, 120, 0, 1, 30, 8}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every slot gets written so no playback reads an empty entry.
		for (int i = 0; i < 256; i++)
			send_action(ACT_LOAD, 8'(i), rand_note());

		// Directed: empty song, rest, wrap, maximum code, pause and resume.
		send_action(ACT_NONE, 8'hFF, 32'hFFFF_FFFF);
		send_action(ACT_PLAY, 0, 0);
		send_action(ACT_RESTART, 0, 0);
		send_action(ACT_LOAD, 0, 32'd300);
		send_action(ACT_LOAD, 1, 32'd207);
		send_action(ACT_LOAD, 2, 32'd499);
		send_action(ACT_LOAD, 3, 32'd0);
		send_action(ACT_LOAD, 255, 32'hFFFF_FFFF);
		drain();
		set_all(10, 120, 120, 7, 0, 10, 4);
		send_action(ACT_PLAY, 0, 0);
		repeat (4) send_action(ACT_TICK, 0, 0);
		repeat (3) send_action(ACT_PEND, 0, 0);
		send_action(ACT_PAUSE, 0, 0);
		send_action(ACT_TICK, 0, 0);
		send_action(ACT_PLAY, 0, 0);
		repeat (5) send_action(ACT_TICK, 0, 0);
		send_action(ACT_STOP, 0, 0);
		send_action(ACT_PEND, 0, 0);
		drain();

		// Random phases over a range of register settings.
		for (int p = 0; p < 7; p++) begin
			set_all(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
				phase_cfg[p][4], phase_cfg[p][5], phase_cfg[p][6]);
			if (p == 1)
				recv_hold = 400;
			for (int n = 0; n < 160; n++) begin
				if (n < 54) begin
					send_idle_pct = 6;
					recv_idle_pct = 83;
				end else if (n < 107) begin
					send_idle_pct = 83;
					recv_idle_pct = 6;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if (n == 0)
					send_action(ACT_RESTART, 8'($urandom), $urandom);
				else
					random_beat();
			end
			drain();
		end

		sb.errors += sb.pending.size();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[sim.f]
rtl/bms_pkg.sv
rtl/bms_div.sv
rtl/bms_song_mem.sv
rtl/buzzer_melody_sequencer_top.sv
verif/buzzer_melody_sequencer_top_tb.sv
